// File: design/tftp_transfer_sequencer_defines.svh
// ----------------------------------------------------------------------------
// TFTP transfer sequencer assertion macros
// Shared property shorthands for the checker of the transfer sequencer.
// ----------------------------------------------------------------------------
`ifndef TFTP_TRANSFER_SEQUENCER_DEFINES_SVH
`define TFTP_TRANSFER_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TFTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tftp transfer sequencer: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define TFTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tftp transfer sequencer: next-cycle property failed");

`endif

// File: design/tfts_pkg.sv
// ----------------------------------------------------------------------------
// TFTP transfer sequencer package
// Codes, constants and transfer payload types shared by the design files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfts_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [7:0]  RETRANSMIT_LIMIT   = 8'd8;
	localparam logic [15:0] RST_REQ_BLOCK_SIZE = 16'd512;
	localparam logic [7:0]  RST_TIMEOUT_LIMIT  = 8'd5;

	typedef enum logic [1:0] {
		CFG_SERVER_ROLE   = 2'd0,
		CFG_DIRECTION     = 2'd1,
		CFG_REQ_BLK_SIZE  = 2'd2,
		CFG_TIMEOUT_LIMIT = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_START    = 2'd0,
		OP_PACKET   = 2'd1,
		OP_SHUTDOWN = 2'd2,
		OP_TIMEOUT  = 2'd3
	} op_t;

	localparam logic [15:0] OPC_DATA  = 16'd3;
	localparam logic [15:0] OPC_ACK   = 16'd4;
	localparam logic [15:0] OPC_ERROR = 16'd5;
	localparam logic [15:0] OPC_OACK  = 16'd6;

	typedef enum logic [2:0] {
		K_NONE   = 3'd0,
		K_RRQ    = 3'd1,
		K_WRQ    = 3'd2,
		K_OACK   = 3'd3,
		K_ACK    = 3'd4,
		K_DATA   = 3'd5,
		K_ERR    = 3'd6,
		K_RESEND = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		R_RUN      = 3'd0,
		R_DONE     = 3'd1,
		R_REMOTE   = 3'd2,
		R_INVALID  = 3'd3,
		R_SHUTDOWN = 3'd4,
		R_TIMEOUTS = 3'd5,
		R_RETRANS  = 3'd6,
		R_OPTION   = 3'd7
	} reason_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] packet_opcode;
		logic [15:0] block_number;
		logic [15:0] payload_length;
		logic        oack_has_block_size;
		logic [15:0] oack_block_size;
		logic [15:0] remote_error;
		logic [15:0] read_length;
	} event_item_t;

	typedef struct packed {
		logic [2:0]  send_kind;
		logic [15:0] send_block;
		logic [15:0] send_data_length;
		logic        deliver_payload;
		logic        finished;
		logic [2:0]  end_reason;
		logic [15:0] remote_error_code;
		logic [31:0] transferred_bytes;
	} result_item_t;

endpackage

// File: design/tfts_event_if.sv
// ----------------------------------------------------------------------------
// TFTP transfer sequencer event channel
// Valid/ready channel that carries one decoded event per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tfts_event_if;
	import tfts_pkg::*;

	logic        valid;
	logic        ready;
	event_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/tfts_result_if.sv
// ----------------------------------------------------------------------------
// TFTP transfer sequencer result channel
// Valid/ready channel that carries one send decision and status per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tfts_result_if;
	import tfts_pkg::*;

	logic         valid;
	logic         ready;
	result_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/tftp_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// TFTP transfer sequencer
// An accepted event is held in the input stage, then its result is loaded into the result register.
// Throughput: one event per cycle while results.ready holds; the state update of
// one event completes as its result register loads, so the next event follows at once.
// Reset clears the transfer state and loads the default configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tftp_transfer_sequencer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tfts_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tfts_pkg::CFG_DATA_W-1:0]    cfg_data,
	tfts_event_if.sink                         events,
	tfts_result_if.source                      results
);
	import tfts_pkg::*;

	logic        server_role_q;
	logic        direction_q;
	logic [15:0] req_size_q;
	logic [7:0]  tmo_limit_q;

	logic [15:0] cur_block_q, cur_block_n;
	logic        last_seen_q, last_seen_n;
	logic [15:0] neg_size_q, neg_size_n;
	logic [7:0]  retx_cnt_q, retx_cnt_n;
	logic [7:0]  tmo_cnt_q, tmo_cnt_n;
	logic [31:0] byte_cnt_q, byte_cnt_n;
	logic        done_q, done_n;
	reason_t     reason_q, reason_n;
	logic [15:0] peer_err_q, peer_err_n;

	event_item_t  ev_s1;
	logic         ev_valid_s1;
	result_item_t res_q, res_n;
	logic         res_valid_q;

	kind_t       kind_n;
	logic [15:0] sblock_n;
	logic [15:0] slen_n;
	logic        deliver_n;

	logic        advance;
	logic        fire;
	logic        receiver;
	logic [15:0] cur_inc;
	logic [15:0] ack_len;
	logic        ack_short;

	assign advance  = !res_valid_q || results.ready;
	assign fire     = ev_valid_s1 && advance;
	assign receiver = ~(server_role_q ^ direction_q);
	assign cur_inc  = cur_block_q + 16'd1;

	assign ack_len   = (ev_s1.read_length > neg_size_q) ? neg_size_q : ev_s1.read_length;
	assign ack_short = ev_s1.read_length < neg_size_q;

	assign events.ready  = !ev_valid_s1 || advance;
	assign results.valid = res_valid_q;
	assign results.data  = res_q;

	always_comb begin
		cur_block_n = cur_block_q;
		last_seen_n = last_seen_q;
		neg_size_n  = neg_size_q;
		retx_cnt_n  = retx_cnt_q;
		tmo_cnt_n   = tmo_cnt_q;
		byte_cnt_n  = byte_cnt_q;
		done_n      = done_q;
		reason_n    = reason_q;
		peer_err_n  = peer_err_q;
		kind_n      = K_NONE;
		sblock_n    = 16'd0;
		slen_n      = 16'd0;
		deliver_n   = 1'b0;

		if (!done_q) begin
			case (ev_s1.op)
				OP_START: begin
					cur_block_n = 16'd0;
					last_seen_n = 1'b0;
					neg_size_n  = req_size_q;
					retx_cnt_n  = 8'd0;
					tmo_cnt_n   = 8'd0;
					byte_cnt_n  = 32'd0;
					if (server_role_q) begin
						kind_n = K_OACK;
					end else begin
						kind_n = direction_q ? K_WRQ : K_RRQ;
					end
				end
				OP_PACKET: begin
					case (ev_s1.packet_opcode)
						OPC_DATA: begin
							if (receiver) begin
								if (ev_s1.block_number == cur_inc) begin
									cur_block_n = ev_s1.block_number;
									deliver_n   = 1'b1;
									byte_cnt_n  = byte_cnt_q + {16'd0, ev_s1.payload_length};
									if (ev_s1.payload_length < neg_size_q) begin
										last_seen_n = 1'b1;
										done_n      = 1'b1;
										reason_n    = R_DONE;
									end
								end
								kind_n   = K_ACK;
								sblock_n = cur_block_n;
							end else begin
								kind_n   = K_ERR;
								done_n   = 1'b1;
								reason_n = R_INVALID;
							end
						end
						OPC_ACK: begin
							if (!receiver) begin
								if (ev_s1.block_number == cur_block_q) begin
									if (last_seen_q) begin
										done_n   = 1'b1;
										reason_n = R_DONE;
									end else begin
										cur_block_n = cur_inc;
										slen_n      = ack_len;
										last_seen_n = last_seen_q | ack_short;
										byte_cnt_n  = byte_cnt_q + {16'd0, ack_len};
										retx_cnt_n  = 8'd0;
										kind_n      = K_DATA;
										sblock_n    = cur_inc;
									end
								end else begin
									slen_n      = ack_len;
									last_seen_n = last_seen_q | ack_short;
									if (retx_cnt_q != 8'hFF) begin
										retx_cnt_n = retx_cnt_q + 8'd1;
									end
									kind_n   = K_DATA;
									sblock_n = cur_block_q;
								end
							end else begin
								kind_n   = K_ERR;
								done_n   = 1'b1;
								reason_n = R_INVALID;
							end
						end
						OPC_ERROR: begin
							peer_err_n = ev_s1.remote_error;
							done_n     = 1'b1;
							reason_n   = R_REMOTE;
						end
						OPC_OACK: begin
							if (ev_s1.oack_has_block_size) begin
								neg_size_n = ev_s1.oack_block_size;
							end
							if (req_size_q < neg_size_n) begin
								done_n   = 1'b1;
								reason_n = R_OPTION;
							end
							if (receiver) begin
								kind_n   = K_ACK;
								sblock_n = cur_block_q;
							end else if (!server_role_q) begin
								cur_block_n = 16'd1;
								slen_n      = (ev_s1.read_length > neg_size_n) ?
									neg_size_n : ev_s1.read_length;
								if (ev_s1.read_length < neg_size_n) begin
									last_seen_n = 1'b1;
								end
								byte_cnt_n = byte_cnt_q + {16'd0, slen_n};
								kind_n     = K_DATA;
								sblock_n   = 16'd1;
							end
						end
						default: begin
							kind_n   = K_ERR;
							done_n   = 1'b1;
							reason_n = R_INVALID;
						end
					endcase
					tmo_cnt_n = 8'd0;
				end
				OP_SHUTDOWN: begin
					done_n   = 1'b1;
					reason_n = R_SHUTDOWN;
				end
				default: begin
					kind_n = K_RESEND;
					if (tmo_cnt_q != 8'hFF) begin
						tmo_cnt_n = tmo_cnt_q + 8'd1;
					end
				end
			endcase

			if (!done_n && tmo_cnt_n >= tmo_limit_q) begin
				done_n   = 1'b1;
				reason_n = R_TIMEOUTS;
			end
			if (!done_n && retx_cnt_n >= RETRANSMIT_LIMIT) begin
				done_n   = 1'b1;
				reason_n = R_RETRANS;
			end
		end

		res_n.send_kind         = kind_n;
		res_n.send_block        = sblock_n;
		res_n.send_data_length  = slen_n;
		res_n.deliver_payload   = deliver_n;
		res_n.finished          = done_n;
		res_n.end_reason        = reason_n;
		res_n.remote_error_code = peer_err_n;
		res_n.transferred_bytes = byte_cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_role_q <= 1'b0;
			direction_q   <= 1'b0;
			req_size_q    <= RST_REQ_BLOCK_SIZE;
			tmo_limit_q   <= RST_TIMEOUT_LIMIT;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SERVER_ROLE:   server_role_q <= cfg_data[0];
				CFG_DIRECTION:     direction_q   <= cfg_data[0];
				CFG_REQ_BLK_SIZE:  req_size_q    <= cfg_data;
				CFG_TIMEOUT_LIMIT: tmo_limit_q   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_block_q <= 16'd0;
			last_seen_q <= 1'b0;
			neg_size_q  <= RST_REQ_BLOCK_SIZE;
			retx_cnt_q  <= 8'd0;
			tmo_cnt_q   <= 8'd0;
			byte_cnt_q  <= 32'd0;
			done_q      <= 1'b0;
			reason_q    <= R_RUN;
			peer_err_q  <= 16'd0;
		end else if (fire) begin
			cur_block_q <= cur_block_n;
			last_seen_q <= last_seen_n;
			neg_size_q  <= neg_size_n;
			retx_cnt_q  <= retx_cnt_n;
			tmo_cnt_q   <= tmo_cnt_n;
			byte_cnt_q  <= byte_cnt_n;
			done_q      <= done_n;
			reason_q    <= reason_n;
			peer_err_q  <= peer_err_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (events.ready) begin
				ev_valid_s1 <= events.valid;
			end
			if (advance) begin
				res_valid_q <= ev_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (events.valid && events.ready) begin
			ev_s1 <= events.data;
		end
		if (fire) begin
			res_q <= res_n;
		end
	end

endmodule

// File: design/tfts_checker.sv
// ----------------------------------------------------------------------------
// TFTP transfer sequencer checker
// Port-level properties of the sequencer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "tftp_transfer_sequencer_defines.svh"

module tfts_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   ev_valid,
	input logic                   ev_ready,
	input logic                   res_valid,
	input logic                   res_ready,
	input tfts_pkg::result_item_t res_data
);
	import tfts_pkg::*;

	logic        ev_fire;
	logic        res_fire;
	logic [2:0]  pending_q;
	logic        fin_seen_q;
	logic        bytes_seen_q;
	logic [31:0] last_bytes_q;

	assign ev_fire  = ev_valid && ev_ready;
	assign res_fire = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= 3'd0;
			fin_seen_q   <= 1'b0;
			bytes_seen_q <= 1'b0;
			last_bytes_q <= 32'd0;
		end else begin
			pending_q <= pending_q + {2'd0, ev_fire} - {2'd0, res_fire};
			if (res_fire) begin
				fin_seen_q   <= fin_seen_q | res_data.finished;
				bytes_seen_q <= 1'b1;
				last_bytes_q <= res_data.transferred_bytes;
			end
		end
	end

	// A result waiting for its sink keeps its contents.
	`TFTS_ASSERT_NEXT(a_result_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_data))

	// Once a finished result has gone out, every later result is inert.
	`TFTS_ASSERT_IMPL(a_finish_sticky, clk, arst_n, res_fire && fin_seen_q, res_data.finished && res_data.send_kind == K_NONE && !res_data.deliver_payload)

	// A resend never moves the byte count.
	`TFTS_ASSERT_IMPL(a_resend_bytes, clk, arst_n, res_fire && bytes_seen_q && res_data.send_kind == K_RESEND, res_data.transferred_bytes == last_bytes_q)

	// At most two events are in flight: the input stage and the result register.
	`TFTS_ASSERT_IMPL(a_depth_bound, clk, arst_n, 1'b1, pending_q <= 3'd2)

	// No result appears without an event behind it.
	`TFTS_ASSERT_IMPL(a_no_phantom, clk, arst_n, res_valid, pending_q != 3'd0)

endmodule

bind tftp_transfer_sequencer tfts_checker u_tfts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.ev_valid  (events.valid),
	.ev_ready  (events.ready),
	.res_valid (results.valid),
	.res_ready (results.ready),
	.res_data  (results.data)
);
